### design/bdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdr_pkg: shared types and constants of the Bayer demosaic
// Field widths, register indexes, mosaic phase tables and the word handed
// from the position tracker to the result sequencer.
// ----------------------------------------------------------------------------
package bdr_pkg;

  localparam int PIX_W   = 8;
  localparam int COORD_W = 12;
  localparam int CFG_W   = 13;
  localparam int PAT_W   = 2;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [CFG_W-1:0] HEIGHT_MAX   = 13'd4096;
  localparam logic [CFG_W-1:0] DIM_MIN      = 13'd2;

  // configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_BAYER_PATTERN = 2'd2;

  // result kinds, as bit positions of the pending mask, in emit order
  localparam int RES_WINDOW = 0;
  localparam int RES_RIGHT  = 1;
  localparam int RES_BOTTOM = 2;
  localparam int RES_N      = 3;

  // column of the red sample inside the 2x2 tile: RGGB, GRBG, BGGR, GBRG
  function automatic logic red_col(input logic [PAT_W-1:0] pat);
    logic v;
    unique case (pat)
      2'd0:    v = 1'b0;
      2'd1:    v = 1'b1;
      2'd2:    v = 1'b1;
      default: v = 1'b0;
    endcase
    return v;
  endfunction

  // row of the red sample inside the 2x2 tile
  function automatic logic red_row(input logic [PAT_W-1:0] pat);
    return pat[1];
  endfunction

  typedef struct packed {
    logic [PIX_W-1:0]   pix;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               dx;      // red column inside the window
    logic               dy;      // red row inside the window
    logic               top_ok;  // line store was read for this column
    logic [RES_N-1:0]   mask;    // results this sample causes
  } item_t;

endpackage
`default_nettype wire

### design/bdr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module bdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### design/bdr_pos.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdr_pos: frame position tracker
// Holds the column and row counters, clamps the frame size and works out,
// for the sample on the input, its window phase and which results it causes.
// ----------------------------------------------------------------------------
module bdr_pos #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          fire_i,
  input  wire logic [bdr_pkg::PIX_W-1:0]     raw_pixel_i,
  input  wire logic [bdr_pkg::CFG_W-1:0]     frame_width_i,
  input  wire logic [bdr_pkg::CFG_W-1:0]     frame_height_i,
  input  wire logic [bdr_pkg::PAT_W-1:0]     bayer_pattern_i,
  output bdr_pkg::item_t                     item_o,
  output logic                               mem_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0]       addr_o
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int MWB = $clog2(MAX_WIDTH + 1);
  localparam int WW  = (MWB > bdr_pkg::CFG_W) ? MWB : bdr_pkg::CFG_W;

  logic [bdr_pkg::COORD_W-1:0] col_q, col_d;
  logic [bdr_pkg::COORD_W-1:0] row_q, row_d;

  logic [WW-1:0]                fw_ext, w_eff, x_ext;
  logic [bdr_pkg::CFG_W-1:0]    h_eff, y_ext;
  logic                         last_col, last_row;

  always_comb begin
    fw_ext = WW'(frame_width_i);
    if (fw_ext < WW'(bdr_pkg::DIM_MIN)) begin
      w_eff = WW'(bdr_pkg::DIM_MIN);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end

    if (frame_height_i < bdr_pkg::DIM_MIN) begin
      h_eff = bdr_pkg::DIM_MIN;
    end else if (frame_height_i > bdr_pkg::HEIGHT_MAX) begin
      h_eff = bdr_pkg::HEIGHT_MAX;
    end else begin
      h_eff = frame_height_i;
    end

    x_ext    = WW'(col_q);
    y_ext    = bdr_pkg::CFG_W'(row_q);
    last_col = x_ext >= (w_eff - WW'(1));
    last_row = y_ext >= (h_eff - bdr_pkg::CFG_W'(1));
  end

  // line store access only for columns it can hold
  assign mem_en_o = x_ext < WW'(MAX_WIDTH);
  assign addr_o   = x_ext[AW-1:0];

  always_comb begin
    item_o        = '0;
    item_o.pix    = raw_pixel_i;
    item_o.x      = col_q;
    item_o.y      = row_q;
    // window origin is one column and one row back, so its parity flips
    item_o.dx     = bdr_pkg::red_col(bayer_pattern_i) ^ ~col_q[0];
    item_o.dy     = bdr_pkg::red_row(bayer_pattern_i) ^ ~row_q[0];
    item_o.top_ok = mem_en_o;
    item_o.mask[bdr_pkg::RES_WINDOW] = (row_q != '0) && (col_q != '0);
    item_o.mask[bdr_pkg::RES_RIGHT]  = (row_q != '0) && last_col;
    item_o.mask[bdr_pkg::RES_BOTTOM] = last_row;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (fire_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + bdr_pkg::COORD_W'(1);
      end else begin
        col_d = col_q + bdr_pkg::COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule
`default_nettype wire

### design/bdr_emit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdr_emit: window stage and result sequencer
// Holds one sample with its line store read, builds the 2x2 window and hands
// the results it causes to the output register one per cycle unless stalled.
// ----------------------------------------------------------------------------
module bdr_emit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            load_i,
  input  wire bdr_pkg::item_t                  item_i,
  input  wire logic [bdr_pkg::PIX_W-1:0]       top_i,
  output logic                                 ready_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [bdr_pkg::PIX_W-1:0]            red_o,
  output logic [bdr_pkg::PIX_W-1:0]            green_o,
  output logic [bdr_pkg::PIX_W-1:0]            blue_o,
  output logic [bdr_pkg::COORD_W-1:0]          pixel_x_o,
  output logic [bdr_pkg::COORD_W-1:0]          pixel_y_o,
  output logic                                 run_last_o
);

  bdr_pkg::item_t                s1_q;
  logic                          s1_v_q;
  logic [bdr_pkg::RES_N-1:0]     pend_q, pend_next;
  logic [bdr_pkg::PIX_W-1:0]     prev_top_q, prev_bot_q;

  logic                          out_v_q;
  logic [bdr_pkg::PIX_W-1:0]     red_q, green_q, blue_q;
  logic [bdr_pkg::COORD_W-1:0]   px_q, py_q;
  logic                          last_q;

  logic [bdr_pkg::PIX_W-1:0]     top, w00, w01, w10, w11;
  logic [bdr_pkg::PIX_W-1:0]     r_win, b_win, ga, gb;
  logic [bdr_pkg::PIX_W:0]       g_sum;
  logic [bdr_pkg::PIX_W-1:0]     red_d, green_d, blue_d;
  logic [bdr_pkg::COORD_W-1:0]   px_d, py_d;
  logic                          emit, retire;

  always_comb begin
    top = s1_q.top_ok ? top_i : '0;
    w00 = prev_top_q;
    w01 = top;
    w10 = prev_bot_q;
    w11 = s1_q.pix;
    r_win = s1_q.dy ? (s1_q.dx ? w11 : w10) : (s1_q.dx ? w01 : w00);
    b_win = s1_q.dy ? (s1_q.dx ? w00 : w01) : (s1_q.dx ? w10 : w11);
    ga    = s1_q.dy ? (s1_q.dx ? w10 : w11) : (s1_q.dx ? w00 : w01);
    gb    = s1_q.dy ? (s1_q.dx ? w01 : w00) : (s1_q.dx ? w11 : w10);
    g_sum = {1'b0, ga} + {1'b0, gb} + (bdr_pkg::PIX_W+1)'(1);
  end

  // pick the lowest pending result, then drop it from the mask
  always_comb begin
    pend_next = pend_q;
    red_d     = '0;
    green_d   = '0;
    blue_d    = '0;
    px_d      = s1_q.x;
    py_d      = s1_q.y;
    priority if (pend_q[bdr_pkg::RES_WINDOW]) begin
      pend_next[bdr_pkg::RES_WINDOW] = 1'b0;
      red_d   = r_win;
      green_d = g_sum[bdr_pkg::PIX_W:1];
      blue_d  = b_win;
      px_d    = s1_q.x - bdr_pkg::COORD_W'(1);
      py_d    = s1_q.y - bdr_pkg::COORD_W'(1);
    end else if (pend_q[bdr_pkg::RES_RIGHT]) begin
      pend_next[bdr_pkg::RES_RIGHT] = 1'b0;
      py_d = s1_q.y - bdr_pkg::COORD_W'(1);
    end else begin
      pend_next[bdr_pkg::RES_BOTTOM] = 1'b0;
    end
  end

  assign emit    = s1_v_q && (pend_q != '0) && (!out_v_q || out_ready_i);
  assign retire  = s1_v_q && ((pend_q == '0) || (emit && (pend_next == '0)));
  assign ready_o = !s1_v_q || retire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      pend_q     <= '0;
      prev_top_q <= '0;
      prev_bot_q <= '0;
      out_v_q    <= 1'b0;
    end else begin
      if (retire) begin
        prev_top_q <= top;
        prev_bot_q <= s1_q.pix;
      end
      if (load_i) begin
        s1_v_q <= 1'b1;
        pend_q <= item_i.mask;
      end else begin
        if (retire) begin
          s1_v_q <= 1'b0;
        end
        if (emit) begin
          pend_q <= pend_next;
        end
      end
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_q <= item_i;
    end
    if (emit) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      px_q    <= px_d;
      py_q    <= py_d;
      last_q  <= pend_next == '0;
    end
  end

  assign out_valid_o = out_v_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign pixel_x_o   = px_q;
  assign pixel_y_o   = py_q;
  assign run_last_o  = last_q;

endmodule
`default_nettype wire

### design/bayer_demosaic_rgb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bayer_demosaic_rgb: streaming 2x2 Bayer to RGB demosaic
// Raw samples in raster order; every output pixel is built from the 2x2
// window to its lower right, with a black right column and bottom row.
//
//   channel  signals                         direction  word
//   input    in_valid_i / in_ready_o         in         raw_pixel_i
//   output   out_valid_o / out_ready_i       out        red/green/blue, x, y, run_last
//   config   cfg_we_i, cfg_index_i           in         cfg_data_i (13 bits)
//
// One sample per cycle: a sample causing at most one word moves through
// the window stage without holding it. A sample in the last column or last
// row can cause two or three words and then holds the window stage until
// all have gone, since the output register takes one word per cycle.
// The first word of a sample passes the line store read, registered with
// the window stage, and then the output register.
// Reset clears counters and flags; the line store needs no clearing pass.
// A stalled output holds the window stage, then the input.
// ----------------------------------------------------------------------------
module bayer_demosaic_rgb #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [bdr_pkg::CFG_W-1:0]     cfg_data_i,

  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [bdr_pkg::PIX_W-1:0]     raw_pixel_i,

  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [bdr_pkg::PIX_W-1:0]          red_o,
  output logic [bdr_pkg::PIX_W-1:0]          green_o,
  output logic [bdr_pkg::PIX_W-1:0]          blue_o,
  output logic [bdr_pkg::COORD_W-1:0]        pixel_x_o,
  output logic [bdr_pkg::COORD_W-1:0]        pixel_y_o,
  output logic                               run_last_o
);

  localparam int AW = $clog2(MAX_WIDTH);

  // configuration registers
  logic [bdr_pkg::CFG_W-1:0] frame_width_q;
  logic [bdr_pkg::CFG_W-1:0] frame_height_q;
  logic [bdr_pkg::PAT_W-1:0] bayer_pattern_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q   <= bdr_pkg::WIDTH_RESET;
      frame_height_q  <= bdr_pkg::HEIGHT_RESET;
      bayer_pattern_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bdr_pkg::REG_FRAME_WIDTH:   frame_width_q   <= cfg_data_i;
        bdr_pkg::REG_FRAME_HEIGHT:  frame_height_q  <= cfg_data_i;
        bdr_pkg::REG_BAYER_PATTERN: bayer_pattern_q <= cfg_data_i[bdr_pkg::PAT_W-1:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  bdr_pkg::item_t          item;
  logic                    in_fire;
  logic                    mem_en;
  logic [AW-1:0]           addr;
  logic [bdr_pkg::PIX_W-1:0] top;

  assign in_fire = in_valid_i && in_ready_o;

  // counters advance on every accepted sample
  bdr_pos #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_pos (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (in_fire),
    .raw_pixel_i    (raw_pixel_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .bayer_pattern_i(bayer_pattern_q),
    .item_o         (item),
    .mem_en_o       (mem_en),
    .addr_o         (addr)
  );

  // previous row: read the old sample and overwrite it in the same cycle;
  // read data holds until the next accepted sample
  bdr_ram #(
    .WIDTH(bdr_pkg::PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (in_fire && mem_en),
    .waddr_i(addr),
    .wdata_i(raw_pixel_i),
    .re_i   (in_fire && mem_en),
    .raddr_i(addr),
    .rdata_o(top)
  );

  bdr_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_fire),
    .item_i     (item),
    .top_i      (top),
    .ready_o    (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .red_o      (red_o),
    .green_o    (green_o),
    .blue_o     (blue_o),
    .pixel_x_o  (pixel_x_o),
    .pixel_y_o  (pixel_y_o),
    .run_last_o (run_last_o)
  );

`ifndef SYNTHESIS
  // the input only backs up behind a word that is on its way out
  a_stall_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> out_valid_o)
    else $error("input stalled with no word behind it");

  // the words of one sample follow each other without a gap
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !run_last_o |=> out_valid_o)
    else $error("gap inside a run of words");

  // a sample in column zero never asks for a window word
  a_window_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (item.x == '0) |-> !item.mask[bdr_pkg::RES_WINDOW])
    else $error("window word requested at column zero");
`endif

endmodule
`default_nettype wire
